// ===== src/sm4_pkg.sv =====
// sm4 block cipher package: action codes, sequencer states, round count, s-box table
// no dependencies; used by sm4_round and sm4_block_encrypt_decrypt
package sm4_pkg;

    localparam int NUM_ROUNDS = 32;
    localparam int RND_W      = $clog2(NUM_ROUNDS);

    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_ENCRYPT = 2'd1;
    localparam logic [1:0] ACT_DECRYPT = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ROUND,
        ST_DONE
    } sm4_state_t;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

endpackage

// ===== src/sm4_round.sv =====
// sm4 round function: new word = w0 ^ L(tau(w1 ^ w2 ^ w3 ^ rk))
// depends on sm4_pkg for the s-box table
module sm4_round (
    input  logic [31:0] w0,
    input  logic [31:0] w1,
    input  logic [31:0] w2,
    input  logic [31:0] w3,
    input  logic [31:0] rk,
    output logic [31:0] fresh
);

    logic [31:0] mix;
    logic [31:0] sub;
    logic [31:0] lin;

    assign mix = w1 ^ w2 ^ w3 ^ rk;

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            sub[b*8 +: 8] = sm4_pkg::SBOX[mix[b*8 +: 8]];
        end
    end

    assign lin = sub
               ^ {sub[29:0], sub[31:30]}
               ^ {sub[21:0], sub[31:22]}
               ^ {sub[13:0], sub[31:14]}
               ^ {sub[7:0],  sub[31:8]};

    assign fresh = w0 ^ lin;

endmodule

// ===== src/sm4_block_encrypt_decrypt.sv =====
// sm4 block encrypt/decrypt top level: round-key memory, round sequencer, output register
// depends on sm4_pkg and sm4_round
//
//  channel  ports                                                  direction
//  s_       s_valid s_ready s_action s_key_slot s_key_word
//           s_block_high s_block_low                               request in
//  m_       m_valid m_ready m_result_high m_result_low             result out
//
// a key load writes the key memory on acceptance; an encrypt or decrypt request runs as:
// one key-memory read ahead, 32 rounds through the single round unit, one writeback
// s_ready is low from acceptance of a block request until its result enters the output register
// a result waiting on m_ready stalls the sequencer in its last state; nothing is dropped
// aresetn is synchronous active low and clears control only; the key memory is not cleared
module sm4_block_encrypt_decrypt (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [1:0]   s_action,
    input  logic [4:0]   s_key_slot,
    input  logic [31:0]  s_key_word,
    input  logic [63:0]  s_block_high,
    input  logic [63:0]  s_block_low,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [63:0]  m_result_high,
    output logic [63:0]  m_result_low
);

    sm4_pkg::sm4_state_t           st_reg, st_next;
    logic [sm4_pkg::RND_W-1:0]     rnd_reg, rnd_next;
    logic [sm4_pkg::RND_W-1:0]     rd_idx;
    logic [sm4_pkg::RND_W-1:0]     key_addr;
    logic                          dec_reg, dec_next;
    logic [31:0]                   w_reg [4];
    logic [31:0]                   w_next [4];
    logic [31:0]                   key_rd_reg;
    logic [31:0]                   key_mem [sm4_pkg::NUM_ROUNDS];
    logic                          m_valid_reg, m_valid_next;
    logic [63:0]                   m_result_high_reg;
    logic [63:0]                   m_result_low_reg;
    logic                          load_out;
    logic                          key_we;
    logic [31:0]                   fresh;

    assign s_ready       = (st_reg == sm4_pkg::ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_result_high = m_result_high_reg;
    assign m_result_low  = m_result_low_reg;

    assign key_we = s_valid && s_ready && (s_action == sm4_pkg::ACT_LOAD);

    // address of the key needed in the next round
    assign rd_idx   = (st_reg == sm4_pkg::ST_ROUND) ? rnd_reg + 1'b1 : rnd_reg;
    assign key_addr = dec_reg ? ~rd_idx : rd_idx;

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[s_key_slot] <= s_key_word;
        end
        key_rd_reg <= key_mem[key_addr];
    end

    sm4_round u_round (
        .w0    (w_reg[0]),
        .w1    (w_reg[1]),
        .w2    (w_reg[2]),
        .w3    (w_reg[3]),
        .rk    (key_rd_reg),
        .fresh (fresh)
    );

    always_comb begin
        st_next      = st_reg;
        rnd_next     = rnd_reg;
        dec_next     = dec_reg;
        w_next       = w_reg;
        load_out     = 1'b0;
        unique case (st_reg)
            sm4_pkg::ST_IDLE: begin
                if (s_valid && (s_action == sm4_pkg::ACT_ENCRYPT ||
                                s_action == sm4_pkg::ACT_DECRYPT)) begin
                    dec_next  = (s_action == sm4_pkg::ACT_DECRYPT);
                    w_next[0] = s_block_high[63:32];
                    w_next[1] = s_block_high[31:0];
                    w_next[2] = s_block_low[63:32];
                    w_next[3] = s_block_low[31:0];
                    rnd_next  = '0;
                    st_next   = sm4_pkg::ST_FETCH;
                end
            end
            sm4_pkg::ST_FETCH: begin
                st_next = sm4_pkg::ST_ROUND;
            end
            sm4_pkg::ST_ROUND: begin
                w_next[0] = w_reg[1];
                w_next[1] = w_reg[2];
                w_next[2] = w_reg[3];
                w_next[3] = fresh;
                rnd_next  = rnd_reg + 1'b1;
                if (rnd_reg == sm4_pkg::RND_W'(sm4_pkg::NUM_ROUNDS - 1)) begin
                    st_next = sm4_pkg::ST_DONE;
                end
            end
            sm4_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out = 1'b1;
                    st_next  = sm4_pkg::ST_IDLE;
                end
            end
            default: begin
                st_next = sm4_pkg::ST_IDLE;
            end
        endcase
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= sm4_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            rnd_reg     <= '0;
            dec_reg     <= 1'b0;
        end else begin
            st_reg      <= st_next;
            m_valid_reg <= m_valid_next;
            rnd_reg     <= rnd_next;
            dec_reg     <= dec_next;
        end
    end

    // output words in reverse order
    always_ff @(posedge aclk) begin
        w_reg <= w_next;
        if (load_out) begin
            m_result_high_reg <= {w_reg[3], w_reg[2]};
            m_result_low_reg  <= {w_reg[1], w_reg[0]};
        end
    end

    a_block_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready &&
        (s_action == sm4_pkg::ACT_ENCRYPT || s_action == sm4_pkg::ACT_DECRYPT)
        |=> st_reg == sm4_pkg::ST_FETCH)
        else $error("block request did not start the sequencer");

    a_fetch_round0: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == sm4_pkg::ST_FETCH |-> rnd_reg == '0)
        else $error("round counter not cleared at key prefetch");

    a_last_round: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == sm4_pkg::ST_ROUND && rnd_reg == sm4_pkg::RND_W'(sm4_pkg::NUM_ROUNDS - 1)
        |=> st_reg == sm4_pkg::ST_DONE)
        else $error("sequencer did not finish after the last round");

    a_writeback: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == sm4_pkg::ST_DONE && (!m_valid_reg || m_ready)
        |=> m_valid_reg && st_reg == sm4_pkg::ST_IDLE)
        else $error("result not written to output register");

endmodule

// ===== test/sm4_block_encrypt_decrypt_tb.sv =====
// self-checking testbench for sm4_block_encrypt_decrypt: key loads, encrypt and decrypt requests
// with a local sm4 predictor, random idle on the request side and random stall on the result side
// depends on sm4_pkg and the sm4_block_encrypt_decrypt rtl
module sm4_block_encrypt_decrypt_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam int RANDOM_PER_PHASE = 300;
    localparam int NUM_DIRECTED = 20;

    typedef struct packed {
        logic [1:0]  act;
        logic [4:0]  slot;
        logic [31:0] word;
        logic [63:0] hi;
        logic [63:0] lo;
    } req_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } block_t;

    localparam logic [7:0] SBOX_BYTES [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // directed requests, run after every key slot has been loaded
    localparam req_t DIRECTED_REQS [NUM_DIRECTED] = '{
        '{sm4_pkg::ACT_ENCRYPT, 5'd0,  32'h0,        64'h0,                64'h0},
        '{sm4_pkg::ACT_ENCRYPT, 5'd0,  32'h0,        64'hffffffffffffffff, 64'hffffffffffffffff},
        '{sm4_pkg::ACT_DECRYPT, 5'd0,  32'h0,        64'h0,                64'h0},
        '{sm4_pkg::ACT_DECRYPT, 5'd31, 32'hffffffff, 64'hffffffffffffffff, 64'hffffffffffffffff},
        '{sm4_pkg::ACT_ENCRYPT, 5'd7,  32'h12345678, 64'h0123456789abcdef, 64'hfedcba9876543210},
        '{sm4_pkg::ACT_DECRYPT, 5'd7,  32'h12345678, 64'h0123456789abcdef, 64'hfedcba9876543210},
        '{ACT_NONE,             5'd31, 32'hffffffff, 64'hffffffffffffffff, 64'hffffffffffffffff},
        '{sm4_pkg::ACT_ENCRYPT, 5'd0,  32'h0,        64'h8000000000000000, 64'h0000000000000001},
        '{sm4_pkg::ACT_LOAD,    5'd0,  32'hffffffff, 64'hffffffffffffffff, 64'hffffffffffffffff},
        '{sm4_pkg::ACT_LOAD,    5'd31, 32'h00000000, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555},
        '{sm4_pkg::ACT_ENCRYPT, 5'd0,  32'h0,        64'haaaaaaaaaaaaaaaa, 64'h5555555555555555},
        '{sm4_pkg::ACT_DECRYPT, 5'd0,  32'h0,        64'h5555555555555555, 64'haaaaaaaaaaaaaaaa},
        '{ACT_NONE,             5'd0,  32'h0,        64'h0,                64'h0},
        '{sm4_pkg::ACT_LOAD,    5'd15, 32'ha5a5a5a5, 64'h0,                64'h0},
        '{sm4_pkg::ACT_ENCRYPT, 5'd0,  32'h0,        64'h0,                64'hffffffffffffffff},
        '{sm4_pkg::ACT_DECRYPT, 5'd0,  32'h0,        64'hffffffffffffffff, 64'h0},
        '{sm4_pkg::ACT_LOAD,    5'd16, 32'h5a5a5a5a, 64'hffffffffffffffff, 64'h0},
        '{sm4_pkg::ACT_ENCRYPT, 5'd16, 32'h0,        64'h0123456789abcdef, 64'hfedcba9876543210},
        '{sm4_pkg::ACT_DECRYPT, 5'd16, 32'h0,        64'h681edf34d206965e, 64'h86b3e94f536e4246},
        '{ACT_NONE,             5'd16, 32'h5a5a5a5a, 64'h0123456789abcdef, 64'hfedcba9876543210}
    };

    logic        aclk;
    logic        aresetn       = 1'b0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action      = sm4_pkg::ACT_LOAD;
    logic [4:0]  s_key_slot    = '0;
    logic [31:0] s_key_word    = '0;
    logic [63:0] s_block_high  = '0;
    logic [63:0] s_block_low   = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [63:0] m_result_high;
    logic [63:0] m_result_low;

    logic [31:0] round_key_mem [32];
    block_t      pending_blocks [$];
    int          sender_idle_pct = 0;
    int          sink_stall_pct  = 0;
    int          mismatches      = 0;

    sm4_block_encrypt_decrypt DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_key_slot    (s_key_slot),
        .s_key_word    (s_key_word),
        .s_block_high  (s_block_high),
        .s_block_low   (s_block_low),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_high (m_result_high),
        .m_result_low  (m_result_low)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10ms;
        $display("CHECK FAILED");
        $finish;
    end

    // s-box on each byte followed by the linear diffusion
    function automatic logic [31:0] sbox_diffuse(input logic [31:0] v);
        logic [31:0] s;
        s = {SBOX_BYTES[v[31:24]], SBOX_BYTES[v[23:16]], SBOX_BYTES[v[15:8]], SBOX_BYTES[v[7:0]]};
        return s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]} ^ {s[13:0], s[31:14]}
                 ^ {s[7:0], s[31:8]};
    endfunction

    function automatic block_t sm4_cipher(input logic [63:0] hi, input logic [63:0] lo,
                                          input bit reverse);
        logic [31:0] w [4];
        logic [31:0] fresh;
        block_t      res;
        int          k;
        w[0] = hi[63:32];
        w[1] = hi[31:0];
        w[2] = lo[63:32];
        w[3] = lo[31:0];
        for (int r = 0; r < sm4_pkg::NUM_ROUNDS; r++) begin
            k = reverse ? sm4_pkg::NUM_ROUNDS - 1 - r : r;
            fresh = w[0] ^ sbox_diffuse(w[1] ^ w[2] ^ w[3] ^ round_key_mem[k]);
            w[0] = w[1];
            w[1] = w[2];
            w[2] = w[3];
            w[3] = fresh;
        end
        res.hi = {w[3], w[2]};
        res.lo = {w[1], w[0]};
        return res;
    endfunction

    task automatic send_request(input req_t req);
        @(negedge aclk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= req.act;
        s_key_slot   <= req.slot;
        s_key_word   <= req.word;
        s_block_high <= req.hi;
        s_block_low  <= req.lo;
        do @(posedge aclk); while (!s_ready);
        case (req.act)
            sm4_pkg::ACT_LOAD:    round_key_mem[req.slot] = req.word;
            sm4_pkg::ACT_ENCRYPT: pending_blocks.push_back(sm4_cipher(req.hi, req.lo, 1'b0));
            sm4_pkg::ACT_DECRYPT: pending_blocks.push_back(sm4_cipher(req.hi, req.lo, 1'b1));
            default: ;
        endcase
    endtask

    function automatic req_t random_request();
        req_t    req;
        int unsigned pick;
        pick     = $urandom_range(0, 99);
        req.act  = pick < 25 ? sm4_pkg::ACT_LOAD : pick < 60 ? sm4_pkg::ACT_ENCRYPT
                 : pick < 95 ? sm4_pkg::ACT_DECRYPT : ACT_NONE;
        req.slot = 5'($urandom_range(0, 31));
        req.word = $urandom;
        req.hi   = {$urandom, $urandom};
        req.lo   = {$urandom, $urandom};
        return req;
    endfunction

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        block_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_blocks.size() == 0) begin
                $display("%t unexpected result: %h %h", $realtime, m_result_high, m_result_low);
                mismatches++;
            end else begin
                want = pending_blocks.pop_front();
                if (m_result_high !== want.hi) begin
                    $display("%t result_high mismatch: expected %h actual %h",
                             $realtime, want.hi, m_result_high);
                    mismatches++;
                end
                if (m_result_low !== want.lo) begin
                    $display("%t result_low mismatch: expected %h actual %h",
                             $realtime, want.lo, m_result_low);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        req_t req;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // fill every key slot, extremes at both ends
        for (int slot = 0; slot < 32; slot++) begin
            req      = random_request();
            req.act  = sm4_pkg::ACT_LOAD;
            req.slot = 5'(slot);
            if (slot == 0) req.word = 32'h0;
            if (slot == 31) req.word = 32'hffffffff;
            send_request(req);
        end

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            send_request(DIRECTED_REQS[i]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin sender_idle_pct = 52; sink_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin sender_idle_pct = 20; sink_stall_pct = 20; end
            endcase
            repeat (RANDOM_PER_PHASE) send_request(random_request());
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
